### hw/rtl/video_switch_routing_controller_core_macros.svh
// Assertion macros for the video switch routing controller.
// Each macro expects clk and rst in scope.
`ifndef VIDEO_SWITCH_ROUTING_CONTROLLER_CORE_MACROS_SVH
`define VIDEO_SWITCH_ROUTING_CONTROLLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VSRC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define VSRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VSRC_ASSERT_SAME(label, ante, cons, msg)
`define VSRC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hw/rtl/vsrc_pkg.sv
`default_nettype none

package vsrc_pkg;

  localparam int VSRC_NUM_OUTPUTS            = 8;
  localparam int VSRC_NUM_SOURCES            = 13;
  localparam int VSRC_NUM_COMMANDED_CAMERAS  = 10;

  localparam logic [3:0] OUT_FIRST_MON  = 4'd0;
  localparam logic [3:0] OUT_MUX_LEFT   = 4'd4;
  localparam logic [3:0] OUT_MUX_RIGHT  = 4'd7;
  localparam logic [3:0] IN_FORWARD_BAY = 4'd0;
  localparam logic [3:0] IN_ARM_PORT    = 4'd4;
  localparam logic [3:0] IN_PL3         = 4'd9;
  localparam logic [3:0] IN_MUX1        = 4'd10;
  localparam logic [3:0] IN_TEST        = 4'd12;
  localparam logic [3:0] VC_FIRST_CAM   = 4'd0;
  localparam logic [3:0] VC_ARM_CAM     = 4'd9;
  localparam logic [3:0] NO_CAMERA      = 4'd10;

  typedef struct packed {
    logic [3:0]  supply_bits;
    logic [4:0]  power_on_buttons;
    logic [4:0]  power_off_buttons;
    logic [7:0]  output_buttons;
    logic [12:0] source_buttons;
    logic [7:0]  panel_commands;
    logic [3:0]  manual_commands;
    logic [3:0]  manual_camera;
  } vsrc_in_t;

  typedef struct packed {
    logic        powered;
    logic [4:0]  cam_power;
    logic [7:0]  output_lamps;
    logic [12:0] source_lamps;
    logic [3:0]  move_camera;
    logic [3:0]  move_command;
    logic [3:0]  zoom_camera;
    logic [1:0]  zoom_command;
    logic        fast_rate;
  } vsrc_out_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } vsrc_hit_t;

  function automatic vsrc_hit_t lowest_set(input logic [15:0] v, input int n);
    vsrc_hit_t hit;
    hit.found = 1'b0;
    hit.idx   = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i] && (i < n)) begin
        hit.found = 1'b1;
        hit.idx   = 4'(i);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/video_switch_routing_controller_core.sv
// Video switch routing controller core.
// Pipeline: each input beat passes the input register, then the result register.
// Throughput: one beat per cycle; both stages move together when the result is free.
// Reset (rst, synchronous, active high): pipeline empty, first monitor selected,
// every route at the forward bay, all camera power off.
`default_nettype none

module video_switch_routing_controller_core #(
  parameter int NUM_OUTPUTS           = vsrc_pkg::VSRC_NUM_OUTPUTS,
  parameter int NUM_SOURCES           = vsrc_pkg::VSRC_NUM_SOURCES,
  parameter int NUM_COMMANDED_CAMERAS = vsrc_pkg::VSRC_NUM_COMMANDED_CAMERAS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire vsrc_pkg::vsrc_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output vsrc_pkg::vsrc_out_t      out_data
);

  import vsrc_pkg::*;

  `include "video_switch_routing_controller_core_macros.svh"

  logic      item_valid;
  vsrc_in_t  item;
  vsrc_out_t result;
  logic      advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  vsrc_state #(
    .NUM_OUTPUTS           (NUM_OUTPUTS),
    .NUM_SOURCES           (NUM_SOURCES),
    .NUM_COMMANDED_CAMERAS (NUM_COMMANDED_CAMERAS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  `VSRC_ASSERT_SAME(a_no_move_idle, out_valid && out_data.move_camera == NO_CAMERA,
                    out_data.move_command == 4'd0, "move command without camera")
  `VSRC_ASSERT_SAME(a_no_zoom_idle, out_valid && out_data.zoom_camera == NO_CAMERA,
                    out_data.zoom_command == 2'd0, "zoom command without camera")
  `VSRC_ASSERT_NEXT(a_item_kept, item_valid && !advance, item_valid && $stable(item),
                    "pending beat lost")

endmodule

`default_nettype wire

### hw/rtl/vsrc_state.sv
`default_nettype none

module vsrc_state #(
  parameter int NUM_OUTPUTS           = vsrc_pkg::VSRC_NUM_OUTPUTS,
  parameter int NUM_SOURCES           = vsrc_pkg::VSRC_NUM_SOURCES,
  parameter int NUM_COMMANDED_CAMERAS = vsrc_pkg::VSRC_NUM_COMMANDED_CAMERAS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire vsrc_pkg::vsrc_in_t item,
  output vsrc_pkg::vsrc_out_t     result
);

  import vsrc_pkg::*;

  `include "video_switch_routing_controller_core_macros.svh"

  localparam int SEL_W = $clog2(NUM_OUTPUTS);
  localparam logic [3:0] NCC = 4'(NUM_COMMANDED_CAMERAS);

  logic [SEL_W-1:0] sel;
  logic [SEL_W-1:0] sel_next;
  logic [3:0]       route [NUM_OUTPUTS];
  logic [4:0]       latches;
  logic [4:0]       latches_next;

  logic       powered;
  vsrc_hit_t  out_hit;
  vsrc_hit_t  src_hit;
  logic [3:0] sel_ext;
  logic       mux_out;
  logic       mux_src;
  logic       route_we;
  logic [3:0] insel;
  logic       manual;
  logic [3:0] man_rel;
  logic [3:0] cmd;
  logic [3:0] mcam;
  logic [3:0] mcmd;
  logic [3:0] zcam;
  logic [1:0] zcmd;
  logic [15:0] out_onehot;
  logic [15:0] src_onehot;

  always_comb begin
    powered  = (&item.supply_bits[1:0]) ^ (&item.supply_bits[3:2]);
    out_hit  = lowest_set({8'd0, item.output_buttons}, NUM_OUTPUTS);
    src_hit  = lowest_set({3'd0, item.source_buttons}, NUM_SOURCES);

    sel_next = sel;
    if (powered && out_hit.found) begin
      sel_next = SEL_W'(out_hit.idx);
    end
    sel_ext  = 4'(sel_next);
    mux_out  = (sel_ext >= OUT_MUX_LEFT) && (sel_ext <= OUT_MUX_RIGHT);
    mux_src  = (src_hit.idx >= IN_MUX1) && (src_hit.idx <= IN_TEST);
    route_we = powered && src_hit.found && !(mux_out && mux_src);
    insel    = route_we ? src_hit.idx : route[sel_next];

    latches_next = powered ? ((latches & ~item.power_off_buttons) | item.power_on_buttons)
                           : 5'd0;

    manual  = (item.manual_camera >= VC_FIRST_CAM) && (item.manual_camera <= VC_ARM_CAM);
    man_rel = item.manual_camera - VC_FIRST_CAM;
    mcam    = NO_CAMERA;
    if (manual) begin
      cmd = item.manual_commands;
      if (man_rel < NCC) begin
        mcam = man_rel;
      end
    end else begin
      cmd = item.panel_commands[3:0];
      if ((insel <= IN_ARM_PORT) && (insel < NCC)) begin
        mcam = insel;
      end
    end
    mcmd = 4'd0;
    if (mcam != NO_CAMERA) begin
      mcmd[0] = cmd[0];
      mcmd[1] = !cmd[0] && cmd[1];
      mcmd[2] = cmd[2];
      mcmd[3] = !cmd[2] && cmd[3];
    end

    zcam = NO_CAMERA;
    zcmd = 2'd0;
    if ((insel <= IN_PL3) && (insel < NCC)) begin
      zcam    = insel;
      zcmd[0] = item.panel_commands[4];
      zcmd[1] = !item.panel_commands[4] && item.panel_commands[5];
    end

    out_onehot = 16'd1 << sel_ext;
    src_onehot = 16'd1 << insel;

    if (powered) begin
      result.powered      = 1'b1;
      result.cam_power    = latches_next;
      result.output_lamps = out_onehot[7:0];
      result.source_lamps = src_onehot[12:0];
      result.move_camera  = mcam;
      result.move_command = mcmd;
      result.zoom_camera  = zcam;
      result.zoom_command = zcmd;
      result.fast_rate    = !(item.panel_commands[6] || item.panel_commands[7]);
    end else begin
      result.powered      = 1'b0;
      result.cam_power    = 5'd0;
      result.output_lamps = 8'd0;
      result.source_lamps = 13'd0;
      result.move_camera  = NO_CAMERA;
      result.move_command = 4'd0;
      result.zoom_camera  = NO_CAMERA;
      result.zoom_command = 2'd0;
      result.fast_rate    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel     <= SEL_W'(OUT_FIRST_MON);
      latches <= 5'd0;
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
        route[i] <= IN_FORWARD_BAY;
      end
    end else if (advance) begin
      sel     <= sel_next;
      latches <= latches_next;
      if (route_we) begin
        route[sel_next] <= src_hit.idx;
      end
    end
  end

  `VSRC_ASSERT_NEXT(a_unpowered_clears, advance && !powered, latches == 5'd0, "latches not cleared")
  `VSRC_ASSERT_NEXT(a_hold_sel, !advance, $stable(sel) && $stable(latches), "state moved on stall")
  `VSRC_ASSERT_NEXT(a_refused_keeps, advance && powered && src_hit.found && mux_out && mux_src && (sel_next == sel), $stable(route[sel]), "refused source written")

endmodule

`default_nettype wire

### verif/video_switch_routing_controller_core_tb.sv
`timescale 1ns / 1ps

module video_switch_routing_controller_core_tb;
  import vsrc_pkg::*;

  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_TICKS = 475;
  localparam int MAX_PRINTS   = 40;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  vsrc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  vsrc_out_t out_data;

  vsrc_in_t  tick_q[$];
  vsrc_out_t due_results[$];
  vsrc_out_t due_now;

  int        sel_output;
  logic [3:0] route_tbl [VSRC_NUM_OUTPUTS];
  logic [4:0] cam_latches;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int err_count = 0;
  int ticks_sent = 0;
  int results_seen = 0;

  video_switch_routing_controller_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic vsrc_out_t predict_tick(vsrc_in_t t);
    vsrc_out_t  r;
    logic       chain_a;
    logic       chain_b;
    int         out_idx;
    int         src_idx;
    logic [3:0] routed;
    logic [3:0] steer;
    logic [3:0] move_cam;
    logic       mux_out;
    logic       mux_src;
    r = '0;
    r.move_camera = NO_CAMERA;
    r.zoom_camera = NO_CAMERA;
    chain_a = t.supply_bits[0] & t.supply_bits[1];
    chain_b = t.supply_bits[2] & t.supply_bits[3];
    if (chain_a == chain_b) begin
      cam_latches = '0;
      return r;
    end
    cam_latches = (cam_latches & ~t.power_off_buttons) | t.power_on_buttons;

    out_idx = -1;
    for (int i = VSRC_NUM_OUTPUTS - 1; i >= 0; i--) begin
      if (t.output_buttons[i]) out_idx = i;
    end
    if (out_idx >= 0) sel_output = out_idx;

    src_idx = -1;
    for (int i = VSRC_NUM_SOURCES - 1; i >= 0; i--) begin
      if (t.source_buttons[i]) src_idx = i;
    end
    if (src_idx >= 0) begin
      mux_out = (sel_output >= OUT_MUX_LEFT) && (sel_output <= OUT_MUX_RIGHT);
      mux_src = (src_idx >= IN_MUX1) && (src_idx <= IN_TEST);
      if (!(mux_out && mux_src)) route_tbl[sel_output] = 4'(src_idx);
    end
    routed = route_tbl[sel_output];

    move_cam = NO_CAMERA;
    if (t.manual_camera >= VC_FIRST_CAM && t.manual_camera <= VC_ARM_CAM) begin
      steer = t.manual_commands;
      if (int'(t.manual_camera - VC_FIRST_CAM) < VSRC_NUM_COMMANDED_CAMERAS)
        move_cam = t.manual_camera - VC_FIRST_CAM;
    end else begin
      steer = t.panel_commands[3:0];
      if (routed <= IN_ARM_PORT && int'(routed) < VSRC_NUM_COMMANDED_CAMERAS)
        move_cam = routed;
    end
    r.move_camera = move_cam;
    if (move_cam != NO_CAMERA) begin
      if (steer[0]) r.move_command[0] = 1'b1;
      else if (steer[1]) r.move_command[1] = 1'b1;
      if (steer[2]) r.move_command[2] = 1'b1;
      else if (steer[3]) r.move_command[3] = 1'b1;
    end

    if (routed <= IN_PL3 && int'(routed) < VSRC_NUM_COMMANDED_CAMERAS) begin
      r.zoom_camera = routed;
      if (t.panel_commands[4]) r.zoom_command = 2'd1;
      else if (t.panel_commands[5]) r.zoom_command = 2'd2;
    end

    r.powered      = 1'b1;
    r.cam_power    = cam_latches;
    r.output_lamps = 8'(1 << sel_output);
    r.source_lamps = 13'(1 << routed);
    r.fast_rate    = (t.panel_commands[7:6] == 2'b00);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  task automatic push_tick(logic [3:0] sup, logic [4:0] pon, logic [4:0] poff,
                           logic [7:0] outb, logic [12:0] srcb, logic [7:0] panel,
                           logic [3:0] man, logic [3:0] mcam);
    vsrc_in_t t;
    t.supply_bits       = sup;
    t.power_on_buttons  = pon;
    t.power_off_buttons = poff;
    t.output_buttons    = outb;
    t.source_buttons    = srcb;
    t.panel_commands    = panel;
    t.manual_commands   = man;
    t.manual_camera     = mcam;
    tick_q.push_back(t);
  endtask

  function automatic logic [15:0] pick_buttons(int width);
    int r;
    r = $urandom_range(99);
    if (r < 45) return '0;
    if (r < 80) return 16'(1 << $urandom_range(width - 1));
    return 16'($urandom) & 16'((1 << width) - 1);
  endfunction

  task automatic queue_random_ticks(int n);
    logic [3:0] sup;
    logic [7:0] panel;
    logic [3:0] mcam;
    int         r;
    repeat (n) begin
      sup = 4'($urandom);
      if ($urandom_range(99) < 85) begin
        while ((sup[0] & sup[1]) == (sup[2] & sup[3])) sup = 4'($urandom);
      end
      panel = 8'($urandom);
      if ($urandom_range(1)) panel[7:6] = 2'b00;
      r = $urandom_range(99);
      if (r < 45) mcam = NO_CAMERA;
      else if (r < 80) mcam = 4'($urandom_range(9));
      else mcam = 4'($urandom_range(15));
      push_tick(sup, 5'(pick_buttons(5)), 5'(pick_buttons(5)), 8'(pick_buttons(8)),
                13'(pick_buttons(13)), panel, 4'($urandom), mcam);
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    sel_output  = OUT_FIRST_MON;
    cam_latches = '0;
    foreach (route_tbl[i]) route_tbl[i] = IN_FORWARD_BAY;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(predict_tick(in_data));
        ticks_sent++;
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          due_now = due_results.pop_front();
          check_field("powered", 16'(out_data.powered), 16'(due_now.powered));
          check_field("cam_power", 16'(out_data.cam_power), 16'(due_now.cam_power));
          check_field("output_lamps", 16'(out_data.output_lamps),
                      16'(due_now.output_lamps));
          check_field("source_lamps", 16'(out_data.source_lamps),
                      16'(due_now.source_lamps));
          check_field("move_camera", 16'(out_data.move_camera),
                      16'(due_now.move_camera));
          check_field("move_command", 16'(out_data.move_command),
                      16'(due_now.move_command));
          check_field("zoom_camera", 16'(out_data.zoom_camera),
                      16'(due_now.zoom_camera));
          check_field("zoom_command", 16'(out_data.zoom_command),
                      16'(due_now.zoom_command));
          check_field("fast_rate", 16'(out_data.fast_rate), 16'(due_now.fast_rate));
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (holds_done != hold_reqs) begin
        holds_done <= holds_done + 1;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (tick_q.size() == 0 && !in_valid && due_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // supply combinations and camera power latches
    push_tick(4'h0, 5'h1F, 5'h00, 8'hFF, 13'h1FFF, 8'hFF, 4'hF, 4'd0);
    push_tick(4'hF, 5'h1F, 5'h00, 8'hFF, 13'h1FFF, 8'h3F, 4'hF, 4'd10);
    push_tick(4'h3, 5'h1F, 5'h1F, 8'h00, 13'h0000, 8'h00, 4'h0, 4'd10);
    push_tick(4'h5, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h00, 4'h0, 4'd10);
    push_tick(4'hC, 5'h0A, 5'h00, 8'h00, 13'h0000, 8'h00, 4'h0, 4'd10);
    push_tick(4'h7, 5'h01, 5'h02, 8'h00, 13'h0000, 8'h00, 4'h0, 4'd10);
    // routing and refused mux sources
    push_tick(4'h3, 5'h00, 5'h00, 8'h01, 13'h1000, 8'h3F, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h80, 13'h0400, 8'h00, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h10, 13'h1000, 8'h00, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h10, 13'h0800, 8'h00, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h10, 13'h0200, 8'h3F, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h2A, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h00, 13'h0010, 8'h15, 4'h0, 4'd10);
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h0A, 4'h0, 4'd10);
    // manual control, rate buttons, button priority and power loss
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h00, 4'hF, 4'd0);
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h00, 4'hA, 4'd9);
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h05, 4'hF, 4'd15);
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h40, 4'h0, 4'd11);
    push_tick(4'hC, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h80, 4'h0, 4'd10);
    push_tick(4'hC, 5'h00, 5'h00, 8'hFF, 13'h1FFF, 8'h00, 4'h0, 4'd10);
    push_tick(4'hC, 5'h00, 5'h00, 8'h80, 13'h1C00, 8'h00, 4'h0, 4'd10);
    push_tick(4'hC, 5'h00, 5'h00, 8'h02, 13'h0800, 8'h00, 4'h0, 4'd10);
    push_tick(4'h0, 5'h00, 5'h00, 8'h04, 13'h0002, 8'h00, 4'h0, 4'd10);
    push_tick(4'h3, 5'h00, 5'h00, 8'h00, 13'h0000, 8'h00, 4'h0, 4'd10);
    wait_drained();

    // no idling, with a long output hold-off up front
    hold_reqs++;
    queue_random_ticks(RANDOM_TICKS);
    wait_drained();

    send_idle_pct = 47;
    stall_pct     = 0;
    queue_random_ticks(RANDOM_TICKS);
    wait_drained();

    send_idle_pct = 0;
    stall_pct     = 47;
    hold_reqs++;
    queue_random_ticks(RANDOM_TICKS);
    wait_drained();

    send_idle_pct = 34;
    stall_pct     = 34;
    queue_random_ticks(RANDOM_TICKS);
    wait_drained();

    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    $display("Run covered %0d panel ticks (directed and random, four idle mixes)", ticks_sent);
    $display("%0d results checked, %0d long output hold-offs", results_seen, holds_done);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### video_switch_routing_controller_core.f
+incdir+hw/rtl
hw/rtl/vsrc_pkg.sv
hw/rtl/vsrc_state.sv
hw/rtl/video_switch_routing_controller_core.sv
verif/video_switch_routing_controller_core_tb.sv
